// ===== rtl/core/mkd_pkg.sv =====
// Shared types, register indexes and the Morse pattern table for the key decoder.
// No dependencies; every module of the decoder imports this package.
package mkd_pkg;

  // Buffer depth and field widths
  localparam int unsigned MAX_SYMBOLS = 5;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned GAP_W       = 3;
  localparam int unsigned MS_W        = 16;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DOT_MIN    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DASH_MIN   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LETTER_GAP = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_GAP   = 8'd3;

  // Register reset values
  localparam logic [MS_W-1:0]  DOT_MIN_RESET    = 16'd40;
  localparam logic [MS_W-1:0]  DASH_MIN_RESET   = 16'd220;
  localparam logic [GAP_W-1:0] LETTER_GAP_RESET = 3'd3;
  localparam logic [GAP_W-1:0] WORD_GAP_RESET   = 3'd5;

  // Highest gap count; the counter saturates here
  localparam logic [GAP_W-1:0] GAP_MAX = 3'd7;

  // Command codes of an input beat
  localparam logic CMD_RELEASE = 1'b0;
  localparam logic CMD_GAP     = 1'b1;

  // Result kinds
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_SPACE = 1'b1;

  // Press classification
  typedef struct packed {
    logic is_symbol;
    logic is_dash;
  } press_class_t;

  // One result item with its valid flag
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [CHAR_W-1:0] char_code;
  } result_t;

  // Build the pattern code: a leading one, then symbols first to last (1 = dash).
  // An empty or overfull buffer yields code zero, which maps to no character.
  function automatic logic [5:0] pattern_code(input logic [MAX_SYMBOLS-1:0] buf_bits,
                                              input logic [COUNT_W-1:0]     count);
    logic [5:0] code;
    code = 6'd0;
    case (count)
      3'd1: code = {5'b00001, buf_bits[0]};
      3'd2: code = {4'b0001, buf_bits[0], buf_bits[1]};
      3'd3: code = {3'b001, buf_bits[0], buf_bits[1], buf_bits[2]};
      3'd4: code = {2'b01, buf_bits[0], buf_bits[1], buf_bits[2], buf_bits[3]};
      3'd5: code = {1'b1, buf_bits[0], buf_bits[1], buf_bits[2], buf_bits[3], buf_bits[4]};
      default: code = 6'd0;
    endcase
    return code;
  endfunction

  // Standard Morse table for A-Z and 0-9; zero means an unknown pattern.
  function automatic logic [CHAR_W-1:0] morse_char(input logic [5:0] code);
    logic [CHAR_W-1:0] ch;
    ch = 7'h00;
    case (code)
      6'd2:  ch = 7'h45; // E
      6'd3:  ch = 7'h54; // T
      6'd4:  ch = 7'h49; // I
      6'd5:  ch = 7'h41; // A
      6'd6:  ch = 7'h4E; // N
      6'd7:  ch = 7'h4D; // M
      6'd8:  ch = 7'h53; // S
      6'd9:  ch = 7'h55; // U
      6'd10: ch = 7'h52; // R
      6'd11: ch = 7'h57; // W
      6'd12: ch = 7'h44; // D
      6'd13: ch = 7'h4B; // K
      6'd14: ch = 7'h47; // G
      6'd15: ch = 7'h4F; // O
      6'd16: ch = 7'h48; // H
      6'd17: ch = 7'h56; // V
      6'd18: ch = 7'h46; // F
      6'd20: ch = 7'h4C; // L
      6'd22: ch = 7'h50; // P
      6'd23: ch = 7'h4A; // J
      6'd24: ch = 7'h42; // B
      6'd25: ch = 7'h58; // X
      6'd26: ch = 7'h43; // C
      6'd27: ch = 7'h59; // Y
      6'd28: ch = 7'h5A; // Z
      6'd29: ch = 7'h51; // Q
      6'd32: ch = 7'h35; // 5
      6'd33: ch = 7'h34; // 4
      6'd35: ch = 7'h33; // 3
      6'd39: ch = 7'h32; // 2
      6'd47: ch = 7'h31; // 1
      6'd48: ch = 7'h36; // 6
      6'd56: ch = 7'h37; // 7
      6'd60: ch = 7'h38; // 8
      6'd62: ch = 7'h39; // 9
      6'd63: ch = 7'h30; // 0
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/morse_key_decoder_unit.sv =====
// Morse key decoder top level: configuration registers, press classifier,
// decoder state and result queue. Depends on mkd_pkg and the mkd_* modules.
//
// Each input beat is either a key release carrying the press length in ms or
// a silent gap tick. The decoder takes one beat per clock cycle and produces
// at most one result beat for it (a decoded letter or digit, or a word space)
// through a two-entry result queue. The queue sets the rate: item_stall rises
// only while both queue entries hold results not yet taken. Configuration
// writes are always ready and take effect on the next beat.
module morse_key_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            command,
  input  logic [mkd_pkg::MS_W-1:0]        press_ms,
  input  logic                            press_confirmed,
  // Result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            kind,
  output logic [mkd_pkg::CHAR_W-1:0]      char_code,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mkd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mkd_pkg::*;

  logic [MS_W-1:0]  dot_min_ms;
  logic [MS_W-1:0]  dash_min_ms;
  logic [GAP_W-1:0] letter_gap_ticks;
  logic [GAP_W-1:0] word_gap_ticks;

  press_class_t cls;
  result_t      result;
  logic         queue_full;
  logic         accept;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min_ms       <= DOT_MIN_RESET;
      dash_min_ms      <= DASH_MIN_RESET;
      letter_gap_ticks <= LETTER_GAP_RESET;
      word_gap_ticks   <= WORD_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DOT_MIN:    dot_min_ms       <= cfg_data;
        CFG_DASH_MIN:   dash_min_ms      <= cfg_data;
        CFG_LETTER_GAP: letter_gap_ticks <= cfg_data[GAP_W-1:0];
        CFG_WORD_GAP:   word_gap_ticks   <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign item_stall = queue_full;
  assign accept     = item_valid & ~item_stall;

  mkd_classify u_classify (
    .press_ms        (press_ms),
    .press_confirmed (press_confirmed),
    .dot_min_ms      (dot_min_ms),
    .dash_min_ms     (dash_min_ms),
    .cls             (cls)
  );

  mkd_state u_state (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .command          (command),
    .cls              (cls),
    .letter_gap_ticks (letter_gap_ticks),
    .word_gap_ticks   (word_gap_ticks),
    .result           (result)
  );

  mkd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .full      (queue_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_kind  (kind),
    .out_char  (char_code)
  );

endmodule

// ===== rtl/core/mkd_classify.sv =====
// Press classifier: decides whether a key release is a dot, a dash or nothing.
// Depends on mkd_pkg.
module mkd_classify (
  input  logic [mkd_pkg::MS_W-1:0] press_ms,
  input  logic                     press_confirmed,
  input  logic [mkd_pkg::MS_W-1:0] dot_min_ms,
  input  logic [mkd_pkg::MS_W-1:0] dash_min_ms,
  output mkd_pkg::press_class_t    cls
);
  import mkd_pkg::*;

  logic above_dot;
  logic below_dash;
  logic above_dash;

  // A confirmed press strictly between the limits is a dot; any press
  // strictly above the dash limit is a dash. The two ranges never overlap.
  always_comb begin
    above_dot     = press_ms > dot_min_ms;
    below_dash    = press_ms < dash_min_ms;
    above_dash    = press_ms > dash_min_ms;
    cls.is_dash   = above_dash;
    cls.is_symbol = above_dash | (above_dot & below_dash & press_confirmed);
  end

endmodule

// ===== rtl/core/mkd_state.sv =====
// Decoder state: symbol buffer, gap counter and space flag, updated once per
// accepted beat, with the letter decode and word-space decision. Depends on mkd_pkg.
module mkd_state (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      command,
  input  mkd_pkg::press_class_t     cls,
  input  logic [mkd_pkg::GAP_W-1:0] letter_gap_ticks,
  input  logic [mkd_pkg::GAP_W-1:0] word_gap_ticks,
  output mkd_pkg::result_t          result
);
  import mkd_pkg::*;

  logic [MAX_SYMBOLS-1:0] symbol_buffer;
  logic [MAX_SYMBOLS-1:0] symbol_buffer_next;
  logic [COUNT_W-1:0]     symbol_count;
  logic [COUNT_W-1:0]     symbol_count_next;
  logic [GAP_W-1:0]       gap_count;
  logic [GAP_W-1:0]       gap_count_next;
  logic                   space_shown;
  logic                   space_shown_next;

  logic                   buffer_full;
  logic                   run_gap;
  logic                   append;
  logic [GAP_W-1:0]       gap_base;
  logic [GAP_W-1:0]       gap_step;
  logic                   decode_now;
  logic [CHAR_W-1:0]      decoded;

  // Work out what this beat does: a gap tick, or a symbol on a full buffer,
  // runs the gap step; a symbol on a buffer with room is appended.
  always_comb begin
    buffer_full = symbol_count >= COUNT_W'(MAX_SYMBOLS);
    run_gap     = (command == CMD_GAP) | (cls.is_symbol & buffer_full);
    append      = (command == CMD_RELEASE) & cls.is_symbol & ~buffer_full;
    // A symbol clears the gap counter before the gap step runs.
    gap_base    = (command == CMD_GAP) ? gap_count : '0;
    gap_step    = (gap_base == GAP_MAX) ? GAP_MAX : gap_base + GAP_W'(1);
    decode_now  = gap_step < letter_gap_ticks;
    decoded     = morse_char(pattern_code(symbol_buffer, symbol_count));
  end

  // Next state and the result of this beat
  always_comb begin
    symbol_buffer_next = symbol_buffer;
    symbol_count_next  = symbol_count;
    gap_count_next     = gap_count;
    space_shown_next   = space_shown;
    result.valid       = 1'b0;
    result.kind        = KIND_CHAR;
    result.char_code   = '0;
    if (accept && run_gap) begin
      gap_count_next = gap_step;
      if (decode_now) begin
        symbol_buffer_next = '0;
        symbol_count_next  = '0;
        space_shown_next   = 1'b0;
        result.valid       = decoded != '0;
        result.char_code   = decoded;
      end else if (gap_step >= word_gap_ticks && !space_shown) begin
        space_shown_next = 1'b1;
        result.valid     = 1'b1;
        result.kind      = KIND_SPACE;
      end
    end else if (accept && append) begin
      gap_count_next                    = '0;
      symbol_buffer_next[symbol_count]  = cls.is_dash;
      symbol_count_next                 = symbol_count + COUNT_W'(1);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_buffer <= '0;
      symbol_count  <= '0;
      gap_count     <= '0;
      space_shown   <= 1'b0;
    end else begin
      symbol_buffer <= symbol_buffer_next;
      symbol_count  <= symbol_count_next;
      gap_count     <= gap_count_next;
      space_shown   <= space_shown_next;
    end
  end

endmodule

// ===== rtl/core/mkd_result_queue.sv =====
// Two-entry result queue between the decoder state and the output channel, so
// a beat is accepted while an earlier result still waits. Depends on mkd_pkg.
module mkd_result_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  mkd_pkg::result_t           push,
  output logic                       full,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [mkd_pkg::CHAR_W-1:0] out_char
);
  import mkd_pkg::*;

  logic [1:0]        entry_kind;
  logic [CHAR_W-1:0] entry_char [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              pop;

  // Status and head of queue
  always_comb begin
    full      = fill == 2'd2;
    out_valid = fill != 2'd0;
    pop       = out_valid & ~out_stall;
    out_kind  = entry_kind[rd_ptr];
    out_char  = entry_char[rd_ptr];
  end

  // Payload storage; written only at the tail
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_kind[wr_ptr] <= push.kind;
      entry_char[wr_ptr] <= push.char_code;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push.valid, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== dv/tb_morse_key_decoder_unit.sv =====
// Self-checking testbench for morse_key_decoder_unit: directed and random key
// and gap beats, with a predictor of the decoded text. Depends on mkd_pkg and the RTL.
module tb_morse_key_decoder_unit;
  import mkd_pkg::*;

  // One decoded result: a character or a word space.
  typedef struct {
    logic              kind;
    logic [CHAR_W-1:0] code;
  } decoded_t;

  // Predicts the decoded text and holds the characters still to come.
  class morse_scoreboard;
    logic [MS_W-1:0]        dot_min;
    logic [MS_W-1:0]        dash_min;
    logic [GAP_W-1:0]       letter_gap;
    logic [GAP_W-1:0]       word_gap;
    logic [MAX_SYMBOLS-1:0] dashes;
    int unsigned            sym_cnt;
    int unsigned            gap_cnt;
    bit                     space_shown;
    logic [CHAR_W-1:0]      pattern_char [64];
    decoded_t               expected_chars [$];
    int unsigned            errors;

    function new();
      string tree;
      byte   c;
      // Morse tree in pattern order: a leading one, then the symbols, dash = 1.
      tree = {"**ETIANMSURWDKGOHVF*L*PJBXCYZQ**",
              "54*3***2*******16*******7***8*90"};
      for (int i = 0; i < 64; i++) begin
        c = tree[i];
        pattern_char[i] = (c == "*") ? 7'd0 : c[6:0];
      end
      dot_min     = DOT_MIN_RESET;
      dash_min    = DASH_MIN_RESET;
      letter_gap  = LETTER_GAP_RESET;
      word_gap    = WORD_GAP_RESET;
      dashes      = '0;
      sym_cnt     = 0;
      gap_cnt     = 0;
      space_shown = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DOT_MIN:    dot_min = val;
        CFG_DASH_MIN:   dash_min = val;
        CFG_LETTER_GAP: letter_gap = val[GAP_W-1:0];
        CFG_WORD_GAP:   word_gap = val[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned chars_pending();
      return expected_chars.size();
    endfunction

    function logic [CHAR_W-1:0] decode_letter();
      int unsigned pat;
      if (sym_cnt == 0) return 7'd0;
      pat = 1;
      for (int i = 0; i < sym_cnt; i++) pat = (pat << 1) | dashes[i];
      return pattern_char[pat];
    endfunction

    // One tick of silence: decode early, emit one word space after a long run.
    function void gap_tick();
      decoded_t          d;
      logic [CHAR_W-1:0] ch;
      if (gap_cnt < GAP_MAX) gap_cnt++;
      if (gap_cnt < letter_gap) begin
        ch = decode_letter();
        dashes = '0;
        sym_cnt = 0;
        space_shown = 1'b0;
        if (ch != 0) begin
          d.kind = KIND_CHAR;
          d.code = ch;
          expected_chars.push_back(d);
        end
      end else if (gap_cnt >= word_gap && !space_shown) begin
        space_shown = 1'b1;
        d.kind = KIND_SPACE;
        d.code = 7'd0;
        expected_chars.push_back(d);
      end
    endfunction

    // A symbol on a full buffer flushes the letter if letter_gap > 1, and is itself dropped.
    function void add_symbol(input logic is_dash);
      gap_cnt = 0;
      if (sym_cnt >= MAX_SYMBOLS) begin
        gap_tick();
      end else begin
        dashes[sym_cnt] = is_dash;
        sym_cnt++;
      end
    endfunction

    function void note_beat(input logic cmd, input logic [MS_W-1:0] press, input logic conf);
      if (cmd == CMD_GAP) gap_tick();
      else if (press > dot_min && press < dash_min && conf) add_symbol(1'b0);
      else if (press > dash_min) add_symbol(1'b1);
    endfunction

    function void check_char(input logic kind_got, input logic [CHAR_W-1:0] code_got);
      decoded_t d;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected result kind %0d char_code %h", $time, kind_got, code_got);
        errors++;
        return;
      end
      d = expected_chars.pop_front();
      if (kind_got !== d.kind) begin
        $display("%0t: kind expected %0d got %0d", $time, d.kind, kind_got);
        errors++;
      end
      if (code_got !== d.code) begin
        $display("%0t: char_code expected %h got %h", $time, d.code, code_got);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic                   command = CMD_RELEASE;
  logic [MS_W-1:0]        press_ms = '0;
  logic                   press_confirmed = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   kind;
  logic [CHAR_W-1:0]      char_code;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_DOT_MIN;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  morse_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     phase_beats = 0;
  int unsigned     hold_reqs = 0;
  int unsigned     hold_done = 0;
  int unsigned     hold_left = 0;

  morse_key_decoder_unit uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .press_ms(press_ms), .press_confirmed(press_confirmed),
    .result_valid(result_valid), .result_stall(result_stall),
    .kind(kind), .char_code(char_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_reqs) begin
      result_stall <= 1'b1;
      hold_done <= hold_reqs;
      hold_left <= 80;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check each accepted result beat, then note each accepted input beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_char(kind, char_code);
      if (item_valid && !item_stall) sb.note_beat(command, press_ms, press_confirmed);
    end
  end

  // Offer one beat after random idle cycles and hold it until accepted.
  task automatic send_beat(input logic cmd, input logic [MS_W-1:0] press, input logic conf);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= cmd;
    press_ms <= press;
    press_confirmed <= conf;
    do @(posedge clk); while (item_stall);
    phase_beats++;
  endtask

  task automatic send_gap();
    send_beat(CMD_GAP, 16'($urandom), 1'($urandom));
  endtask

  // A dot or dash under the current thresholds; falls back when one is impossible.
  task automatic send_symbol(input bit want_dash);
    bit dot_ok;
    bit dash_ok;
    dot_ok = int'(sb.dash_min) > int'(sb.dot_min) + 1;
    dash_ok = sb.dash_min != 16'hFFFF;
    if (dash_ok && (want_dash || !dot_ok))
      send_beat(CMD_RELEASE, 16'($urandom_range(65535, int'(sb.dash_min) + 1)), 1'($urandom));
    else if (dot_ok)
      send_beat(CMD_RELEASE,
                16'($urandom_range(int'(sb.dash_min) - 1, int'(sb.dot_min) + 1)), 1'b1);
    else
      send_beat(CMD_RELEASE, 16'($urandom), 1'($urandom));
  endtask

  // Mostly well-formed letters followed by silence; the rest is noise.
  task automatic random_step();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 75) begin
      n = $urandom_range(5, 1);
      repeat (n) send_symbol(1'($urandom_range(1)));
      n = $urandom_range(8, 1);
      repeat (n) send_gap();
    end else if (pick < 85) begin
      // Overfull letter: the extra symbols flush the buffer when letter_gap > 1.
      n = $urandom_range(8, 6);
      repeat (n) send_symbol(1'($urandom_range(1)));
      send_gap();
    end else if (pick < 93) begin
      send_beat(1'($urandom), 16'($urandom), 1'($urandom));
    end else begin
      case ($urandom_range(4))
        0: send_beat(CMD_RELEASE, sb.dot_min, 1'b1);
        1: send_beat(CMD_RELEASE, sb.dash_min, 1'($urandom));
        2: send_beat(CMD_RELEASE, sb.dot_min + 16'd1, 1'b0);
        3: send_beat(CMD_RELEASE, 16'd0, 1'($urandom));
        default: send_beat(CMD_RELEASE, 16'hFFFF, 1'($urandom));
      endcase
    end
  endtask

  // Wait until every expected beat has come out and the block has settled.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.chars_pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers in one burst; valid stays high between beats.
  task automatic write_config(input logic [MS_W-1:0] dot, input logic [MS_W-1:0] dash,
                              input logic [GAP_W-1:0] lg, input logic [GAP_W-1:0] wg);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  vals [4];
    idx = '{CFG_DOT_MIN, CFG_DASH_MIN, CFG_LETTER_GAP, CFG_WORD_GAP};
    vals = '{dot, dash, {13'd0, lg}, {13'd0, wg}};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [MS_W-1:0]  dots [7];
    logic [MS_W-1:0]  dashes_min [7];
    logic [GAP_W-1:0] letter_gaps [7];
    logic [GAP_W-1:0] word_gaps [7];
    int unsigned      targets [7];
    bit               pressure_done;

    dots        = '{16'd40,  16'd0, 16'd500,  16'hFFFF, 16'd0, 16'd1000, 16'd40};
    dashes_min  = '{16'd220, 16'd2, 16'd3000, 16'd0,    16'd0, 16'hFFFF, 16'd220};
    letter_gaps = '{3'd3, 3'd2, 3'd7, 3'd2, 3'd3, 3'd4, 3'd1};
    word_gaps   = '{3'd5, 3'd7, 3'd7, 3'd1, 3'd5, 3'd2, 3'd1};
    targets     = '{240, 240, 240, 240, 240, 240, 60};
    pressure_done = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset thresholds: edges of each threshold, then letters.
    send_beat(CMD_RELEASE, 16'd0, 1'b1);
    send_beat(CMD_RELEASE, 16'd40, 1'b1);
    send_beat(CMD_RELEASE, 16'd41, 1'b0);
    send_beat(CMD_RELEASE, 16'd41, 1'b1);
    send_beat(CMD_RELEASE, 16'd220, 1'b1);
    send_beat(CMD_RELEASE, 16'd221, 1'b0);
    send_beat(CMD_GAP, 16'hFFFF, 1'b1);
    // Empty-buffer decode, then a run long enough for a word space and saturation.
    repeat (7) send_beat(CMD_GAP, 16'd0, 1'b0);
    // Five dashes, then a dot on the full buffer flushes the digit zero.
    repeat (5) send_beat(CMD_RELEASE, 16'hFFFF, 1'b1);
    send_beat(CMD_RELEASE, 16'd219, 1'b1);
    // An unknown five-symbol pattern decodes to nothing.
    send_beat(CMD_RELEASE, 16'd100, 1'b1);
    send_beat(CMD_RELEASE, 16'd100, 1'b1);
    send_beat(CMD_RELEASE, 16'd300, 1'b0);
    send_beat(CMD_RELEASE, 16'd300, 1'b1);
    send_beat(CMD_RELEASE, 16'd100, 1'b1);
    send_beat(CMD_GAP, 16'h5A5A, 1'b1);
    send_beat(CMD_GAP, 16'hA5A5, 1'b0);

    // Random phases, each with its own thresholds and one of four idling patterns.
    for (int p = 0; p < 7; p++) begin
      drain();
      if (p == 4)
        write_config(16'($urandom_range(2000)), 16'($urandom_range(6000, 2002)),
                     3'($urandom_range(4, 2)), 3'($urandom_range(7, 4)));
      else
        write_config(dots[p], dashes_min[p], letter_gaps[p], word_gaps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      phase_beats = 0;
      while (phase_beats < targets[p]) begin
        // Hold the receiver off once while beats keep coming, to fill the block.
        if (p == 0 && phase_beats >= 20 && !pressure_done) begin
          hold_reqs++;
          pressure_done = 1'b1;
        end
        random_step();
      end
    end
    drain();

    if (sb.errors == 0 && sb.chars_pending() == 0) begin
      $display("[morse_key_decoder_unit] OK");
    end else begin
      $display("[morse_key_decoder_unit] ERROR");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[morse_key_decoder_unit] ERROR");
    $finish;
  end

endmodule
